@@ hw/rtl/blor_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the box list overlap replace block.
// Used by the cell, the top level and the checker; depends on nothing.
package blor_pkg;

   localparam int MAX_BOXES_DEF = 16;
   localparam int CoordW        = 15;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_POINT  = 2'd1;
   localparam logic [1:0] ACT_SMALL  = 2'd2;
   localparam logic [1:0] ACT_READ   = 2'd3;

   localparam logic [1:0] CSR_IOU_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_HIT_BORDER    = 2'd1;
   localparam logic [1:0] CSR_MIN_SIZE      = 2'd2;

   localparam logic [7:0] IOU_THRESHOLD_RST = 8'd77;
   localparam logic [9:0] HIT_BORDER_RST    = 10'd32;
   localparam logic [9:0] MIN_SIZE_RST      = 10'd32;

   typedef struct packed {
      logic [1:0]  action;
      logic [14:0] box_cx;
      logic [14:0] box_cy;
      logic [14:0] box_w;
      logic [14:0] box_h;
      logic [14:0] point_x;
      logic [14:0] point_y;
      logic [3:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [4:0]  box_count;
      logic [4:0]  removed_count;
      logic        dropped_full;
      logic        read_valid;
      logic [14:0] read_cx;
      logic [14:0] read_cy;
      logic [14:0] read_w;
      logic [14:0] read_h;
   } rsp_type;

   typedef struct packed {
      logic [14:0] cx;
      logic [14:0] cy;
      logic [14:0] w;
      logic [14:0] h;
   } box_type;

   typedef struct packed {
      logic [7:0] iou_threshold;
      logic [9:0] hit_border;
      logic [9:0] min_size;
   } cfg_type;

   typedef struct packed {
      logic ld_flag;
      logic shift;
      logic write;
   } cell_ctl_type;

endpackage

@@ hw/rtl/box_list_overlap_replace_top.sv @@
`timescale 1ns / 1ps
// Top level of the box list overlap replace block: control sequencer, registers
// and the chain of list cells. Depends on blor_pkg and blor_cell.
//
// An operation runs the removal test pipeline inside each cell, then the cell
// chain closes one gap per cycle until no marked box is left, then the result
// is written.
// One operation is in flight at a time; a new request beat is taken while the
// previous result beat still waits on the output register.
module box_list_overlap_replace_top #(
   parameter int MAX_BOXES = blor_pkg::MAX_BOXES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  blor_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output blor_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [9:0]        csr_wdata
);
   import blor_pkg::*;

   localparam int CW = $clog2(MAX_BOXES + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_SQUEEZE, ST_FINISH} state_type;

   state_type     state_ff;
   logic [1:0]    step_ff;
   req_type       req_ff;
   logic [CW-1:0] count_ff, removed_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   cfg_type       cfg_ff;

   cell_ctl_type  ctl;
   logic          free_in, room_in, any_drop, rd_ok_in;
   logic [CW-1:0] count_in;

   logic    seen  [MAX_BOXES+1];
   logic    drop  [MAX_BOXES+1];
   box_type boxes [MAX_BOXES+1];
   box_type rd    [MAX_BOXES+1];

   assign seen[0]          = 1'b0;
   assign drop[MAX_BOXES]  = 1'b0;
   assign boxes[MAX_BOXES] = '0;
   assign rd[MAX_BOXES]    = '0;
   assign any_drop         = seen[MAX_BOXES];

   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
      blor_cell #(.MAX_BOXES(MAX_BOXES), .IDX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .count    (count_ff),
         .cfg      (cfg_ff),
         .req      (req_ff),
         .seen_in  (seen[i]),
         .box_nx   (boxes[i+1]),
         .drop_nx  (drop[i+1]),
         .rd_nx    (rd[i+1]),
         .seen_out (seen[i+1]),
         .box_out  (boxes[i]),
         .drop_out (drop[i]),
         .rd_out   (rd[i])
      );
   end

   assign free_in  = !rsp_valid_ff || rsp_ready;
   assign room_in  = int'(count_ff) < MAX_BOXES;
   assign count_in = (req_ff.action == ACT_INSERT && room_in) ? count_ff + 1'b1 : count_ff;
   assign rd_ok_in = (req_ff.action == ACT_READ) && (int'(req_ff.entry_index) < int'(count_ff));

   assign ctl.ld_flag = (state_ff == ST_EVAL) && (step_ff == 2'd3);
   assign ctl.shift   = (state_ff == ST_SQUEEZE) && any_drop;
   assign ctl.write   = (state_ff == ST_FINISH) && free_in &&
                        (req_ff.action == ACT_INSERT) && room_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         count_ff     <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= {IOU_THRESHOLD_RST, HIT_BORDER_RST, MIN_SIZE_RST};
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_IOU_THRESHOLD: cfg_ff.iou_threshold <= csr_wdata[7:0];
               CSR_HIT_BORDER:    cfg_ff.hit_border    <= csr_wdata;
               CSR_MIN_SIZE:      cfg_ff.min_size      <= csr_wdata;
               default:           ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff     <= req_data;
                  removed_ff <= '0;
                  step_ff    <= 2'd0;
                  state_ff   <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  state_ff <= ST_SQUEEZE;
               end
            end
            ST_SQUEEZE: begin
               if (any_drop) begin
                  count_ff   <= count_ff - 1'b1;
                  removed_ff <= removed_ff + 1'b1;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (free_in) begin
                  count_ff               <= count_in;
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.box_count       <= 5'(count_in);
                  rsp_ff.removed_count   <= 5'(removed_ff);
                  rsp_ff.dropped_full    <= (req_ff.action == ACT_INSERT) && !room_in;
                  rsp_ff.read_valid      <= rd_ok_in;
                  rsp_ff.read_cx         <= rd_ok_in ? rd[0].cx : '0;
                  rsp_ff.read_cy         <= rd_ok_in ? rd[0].cy : '0;
                  rsp_ff.read_w          <= rd_ok_in ? rd[0].w : '0;
                  rsp_ff.read_h          <= rd_ok_in ? rd[0].h : '0;
                  state_ff               <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/blor_cell.sv @@
`timescale 1ns / 1ps
// One slot of the box list: holds a box, evaluates its removal test in a short
// pipeline and shifts towards the head during compaction. Depends on blor_pkg.
module blor_cell #(
   parameter int MAX_BOXES = blor_pkg::MAX_BOXES_DEF,
   parameter int IDX       = 0,
   localparam int CW       = $clog2(MAX_BOXES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  blor_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]         count,
   input  blor_pkg::cfg_type     cfg,
   input  blor_pkg::req_type     req,
   input  logic                  seen_in,
   input  blor_pkg::box_type     box_nx,
   input  logic                  drop_nx,
   input  blor_pkg::box_type     rd_nx,
   output logic                  seen_out,
   output blor_pkg::box_type     box_out,
   output logic                  drop_out,
   output blor_pkg::box_type     rd_out
);
   import blor_pkg::*;

   function automatic logic signed [18:0] overlap2(logic [14:0] ca, logic [14:0] sa,
                                                   logic [14:0] cb, logic [14:0] sb);
      logic signed [18:0] la, lb, ra, rb, lft, rgt;
      la  = $signed({3'b000, ca, 1'b0}) - $signed({4'b0000, sa});
      lb  = $signed({3'b000, cb, 1'b0}) - $signed({4'b0000, sb});
      ra  = $signed({3'b000, ca, 1'b0}) + $signed({4'b0000, sa});
      rb  = $signed({3'b000, cb, 1'b0}) + $signed({4'b0000, sb});
      lft = (la > lb) ? la : lb;
      rgt = (ra < rb) ? ra : rb;
      return rgt - lft;
   endfunction

   function automatic logic [15:0] absdiff(logic [14:0] a, logic [14:0] b);
      return (a >= b) ? {1'b0, a - b} << 1 : {1'b0, b - a} << 1;
   endfunction

   box_type            box_ff;
   logic               drop_ff;

   logic signed [18:0] ow_ff, oh_ff;
   logic [29:0]        area_a_ff, area_b_ff;
   logic               hit_a_ff, small_a_ff;
   logic [33:0]        i4_b_ff;
   logic [32:0]        sum4_b_ff;
   logic               hit_b_ff, small_b_ff;
   logic [33:0]        i4_c_ff;
   logic [40:0]        prod_c_ff;
   logic               hit_c_ff, small_c_ff;

   logic [15:0]        lim_x_in, lim_y_in;
   logic               hit_in, small_in, neg_in, sim_in, live_in, drop_in;
   logic [32:0]        u4_in;
   logic               take_in;

   assign lim_x_in = {1'b0, box_ff.w} + {5'b00000, cfg.hit_border, 1'b0};
   assign lim_y_in = {1'b0, box_ff.h} + {5'b00000, cfg.hit_border, 1'b0};
   assign hit_in   = (absdiff(box_ff.cx, req.point_x) < lim_x_in) &&
                     (absdiff(box_ff.cy, req.point_y) < lim_y_in);
   assign small_in = ({5'b00000, cfg.min_size} > box_ff.w) ||
                     ({5'b00000, cfg.min_size} > box_ff.h);
   assign neg_in   = ow_ff[18] | oh_ff[18];
   assign u4_in    = sum4_b_ff - i4_b_ff[32:0];
   assign sim_in   = {i4_c_ff, 8'h00} > {1'b0, prod_c_ff};
   assign live_in  = IDX < int'(count);
   assign take_in  = seen_in | drop_ff;

   always_comb begin
      unique case (req.action)
         ACT_INSERT: drop_in = live_in & sim_in;
         ACT_POINT:  drop_in = live_in & hit_c_ff;
         ACT_SMALL:  drop_in = live_in & small_c_ff;
         default:    drop_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      ow_ff      <= overlap2(box_ff.cx, box_ff.w, req.box_cx, req.box_w);
      oh_ff      <= overlap2(box_ff.cy, box_ff.h, req.box_cy, req.box_h);
      area_a_ff  <= 30'(box_ff.w) * 30'(box_ff.h);
      area_b_ff  <= 30'(req.box_w) * 30'(req.box_h);
      hit_a_ff   <= hit_in;
      small_a_ff <= small_in;
      i4_b_ff    <= neg_in ? 34'd0 : 34'(ow_ff[16:0]) * 34'(oh_ff[16:0]);
      sum4_b_ff  <= {31'(area_a_ff) + 31'(area_b_ff), 2'b00};
      hit_b_ff   <= hit_a_ff;
      small_b_ff <= small_a_ff;
      i4_c_ff    <= i4_b_ff;
      prod_c_ff  <= 41'(cfg.iou_threshold) * 41'(u4_in);
      hit_c_ff   <= hit_b_ff;
      small_c_ff <= small_b_ff;
      if (ctl.shift && take_in) begin
         box_ff <= box_nx;
      end else if (ctl.write && (IDX == int'(count))) begin
         box_ff <= {req.box_cx, req.box_cy, req.box_w, req.box_h};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff <= 1'b0;
      end else if (ctl.ld_flag) begin
         drop_ff <= drop_in;
      end else if (ctl.shift && take_in) begin
         drop_ff <= drop_nx;
      end
   end

   assign seen_out = take_in;
   assign box_out  = box_ff;
   assign drop_out = drop_ff;
   assign rd_out   = (IDX == int'(req.entry_index)) ? box_ff : rd_nx;

endmodule

@@ hw/rtl/blor_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the box list overlap replace top level, and the bind
// that attaches them. Depends on blor_pkg and box_list_overlap_replace_top.
module blor_checker #(
   parameter int MAX_BOXES = blor_pkg::MAX_BOXES_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input blor_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input blor_pkg::rsp_type rsp_data
);
   import blor_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an operation is in flight");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped_full |->
         rsp_data.box_count == 5'(MAX_BOXES) && !rsp_data.read_valid)
      else $error("dropped box without a full list");

   a_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_valid |->
         rsp_data.removed_count == 5'd0 && !rsp_data.dropped_full)
      else $error("read beat reports removals");

   a_idle_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.read_valid |->
         rsp_data.read_cx == 15'd0 && rsp_data.read_w == 15'd0)
      else $error("read fields not cleared");

endmodule

bind box_list_overlap_replace_top blor_checker #(.MAX_BOXES(MAX_BOXES)) u_blor_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
